/* hw/rtl/nrhci_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrhci_pkg
// Shared types and constants of the no-repeat hash choice index core.
// ----------------------------------------------------------------------------
package nrhci_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CHOICE_W = 16;

    localparam logic [31:0] HASH_SEED  = 32'd374761393;
    localparam logic [31:0] HASH_MUL_A = 32'd668265263;
    localparam logic [31:0] HASH_MUL_B = 32'd2246822519;
    localparam logic [31:0] HASH_MUL_C = 32'd3266489917;
    localparam logic [31:0] BACK_SALT  = 32'd13331;

    // remainder unit: bits retired per cycle and steps per operand
    localparam int unsigned FMOD_BITS  = 4;
    localparam int unsigned FMOD_STEPS = WORD_W / FMOD_BITS;

    typedef struct packed {
        logic                start;
        logic                hash_en;
        logic [WORD_W-1:0]   operand;
        logic [CHOICE_W-1:0] divisor;
    } hm_req_t;

    typedef struct packed {
        logic                done;
        logic [CHOICE_W-1:0] result;
    } hm_resp_t;

endpackage

/* hw/rtl/no_repeat_hash_choice_index_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// no_repeat_hash_choice_index_core
// Maps a signed index and a modulus to a non-repeating hash choice; for a
// modulus above two it is served from a window buffer that is rebuilt on a miss.
// ----------------------------------------------------------------------------
// Modulus below three: the result is set at acceptance and goes out via S_DONE.
// Window hit: slot remainder, window check, buffer read, output.
// Rebuild: BUFFER_LENGTH+1 hash-remainder passes, plus one more pass per tail
// entry re-stepped; one transaction at a time.
// Reset clears the window state; the buffer is not cleared (every entry is
// written by a rebuild before it is read).
// ----------------------------------------------------------------------------
module no_repeat_hash_choice_index_core #(
    parameter int unsigned BUFFER_LENGTH = 100
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] index_value,
    input  logic [15:0] modulus,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] choice
);

    localparam int unsigned IDX_W = $clog2(BUFFER_LENGTH);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_SLOT  = 13'b0000000000010,
        S_CHECK = 13'b0000000000100,
        S_FILL  = 13'b0000000001000,
        S_NEXT  = 13'b0000000010000,
        S_BRD   = 13'b0000000100000,
        S_BCMP  = 13'b0000001000000,
        S_BWAIT = 13'b0000010000000,
        S_RDREQ = 13'b0000100000000,
        S_RDATA = 13'b0001000000000,
        S_DONE  = 13'b0010000000000,
        S_SPARE = 13'b0100000000000,
        S_HOLD  = 13'b1000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [31:0]         index_reg, index_next;
    logic [15:0]         mod_reg, mod_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [15:0]         prev_reg, prev_next;
    logic [15:0]         head_reg, head_next;
    logic [15:0]         res_reg, res_next;
    logic [31:0]         wstart_reg, wstart_next;
    logic [15:0]         wmod_reg, wmod_next;
    logic                wvalid_reg, wvalid_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         choice_reg;

    logic [15:0]         buffer_mem [BUFFER_LENGTH];
    logic [15:0]         rd_data_reg;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [15:0]         wr_data;

    nrhci_pkg::hm_req_t  req;
    nrhci_pkg::hm_resp_t resp;

    logic                accept;
    logic                out_free;
    logic [31:0]         pos_ext;
    logic [31:0]         slot_ext;
    logic [31:0]         new_start;
    logic [31:0]         win_end;
    logic                miss;
    logic [16:0]         fwd_sum;
    logic [15:0]         fwd_val;
    logic [16:0]         back_sum;
    logic [15:0]         back_val;

    nrhci_hmod u_hmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .resp  (resp)
    );

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign pos_ext   = {{(32-IDX_W){1'b0}}, pos_reg};
    assign slot_ext  = {{(32-IDX_W){1'b0}}, slot_reg};
    assign new_start = index_reg - slot_ext - 32'(BUFFER_LENGTH / 4);
    assign win_end   = wstart_reg + 32'(BUFFER_LENGTH);
    assign miss      = !wvalid_reg
                       || ($signed(index_reg) < $signed(wstart_reg))
                       || ($signed(index_reg) >= $signed(win_end))
                       || (mod_reg != wmod_reg);

    always_comb
    begin
        fwd_sum = {1'b0, prev_reg} + {1'b0, resp.result} + 17'd1;
        if (fwd_sum >= {1'b0, mod_reg})
            fwd_sum = fwd_sum - {1'b0, mod_reg};
        fwd_val = (pos_reg == '0) ? resp.result : fwd_sum[15:0];
        back_sum = {1'b0, head_reg} + {1'b0, resp.result} + 17'd1;
        if (back_sum >= {1'b0, mod_reg})
            back_sum = back_sum - {1'b0, mod_reg};
        back_val = back_sum[15:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        index_next     = index_reg;
        mod_next       = mod_reg;
        slot_next      = slot_reg;
        pos_next       = pos_reg;
        prev_next      = prev_reg;
        head_next      = head_reg;
        res_next       = res_reg;
        wstart_next    = wstart_reg;
        wmod_next      = wmod_reg;
        wvalid_next    = wvalid_reg;
        out_valid_next = out_valid_reg && out_stall;
        req            = '0;
        rd_en          = 1'b0;
        rd_addr        = slot_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = fwd_val;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    index_next = index_value;
                    mod_next   = modulus;
                    if (modulus < 16'd2)
                    begin
                        res_next   = 16'd0;
                        state_next = S_DONE;
                    end
                    else if (modulus == 16'd2)
                    begin
                        res_next   = {15'd0, index_value[0]};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        req.start   = 1'b1;
                        req.hash_en = 1'b0;
                        req.operand = index_value;
                        req.divisor = 16'(BUFFER_LENGTH);
                        state_next  = S_SLOT;
                    end
                end
            end
            S_SLOT:
            begin
                if (resp.done)
                begin
                    slot_next  = resp.result[IDX_W-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (miss)
                begin
                    wstart_next = new_start;
                    wmod_next   = mod_reg;
                    wvalid_next = 1'b1;
                    pos_next    = '0;
                    req.start   = 1'b1;
                    req.hash_en = 1'b1;
                    req.operand = new_start;
                    req.divisor = mod_reg;
                    state_next  = S_FILL;
                end
                else
                    state_next = S_RDREQ;
            end
            S_FILL:
            begin
                if (resp.done)
                begin
                    wr_en     = 1'b1;
                    prev_next = fwd_val;
                    req.start   = 1'b1;
                    req.hash_en = 1'b1;
                    if (pos_reg == IDX_W'(BUFFER_LENGTH - 1))
                    begin
                        req.operand = wstart_reg + 32'(BUFFER_LENGTH);
                        req.divisor = mod_reg;
                        state_next  = S_NEXT;
                    end
                    else
                    begin
                        pos_next    = pos_reg + IDX_W'(1);
                        req.operand = wstart_reg + pos_ext + 32'd1;
                        req.divisor = mod_reg - 16'd1;
                    end
                end
            end
            S_NEXT:
            begin
                if (resp.done)
                begin
                    head_next  = resp.result;
                    pos_next   = IDX_W'(BUFFER_LENGTH - 1);
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg;
                state_next = S_BCMP;
            end
            S_BCMP:
            begin
                if (rd_data_reg != head_reg)
                    state_next = S_RDREQ;
                else
                begin
                    req.start   = 1'b1;
                    req.hash_en = 1'b1;
                    req.operand = wstart_reg + pos_ext + nrhci_pkg::BACK_SALT;
                    req.divisor = mod_reg - 16'd1;
                    state_next  = S_BWAIT;
                end
            end
            S_BWAIT:
            begin
                if (resp.done)
                begin
                    head_next = back_val;
                    wr_en     = 1'b1;
                    wr_data   = back_val;
                    if (pos_reg == IDX_W'(1))
                        state_next = S_RDREQ;
                    else
                    begin
                        pos_next   = pos_reg - IDX_W'(1);
                        state_next = S_BRD;
                    end
                end
            end
            S_RDREQ:
            begin
                rd_en      = 1'b1;
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                res_next   = rd_data_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wstart_reg    <= '0;
            wmod_reg      <= '0;
            wvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wstart_reg    <= wstart_next;
            wmod_reg      <= wmod_next;
            wvalid_reg    <= wvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
        mod_reg   <= mod_next;
        slot_reg  <= slot_next;
        pos_reg   <= pos_next;
        prev_reg  <= prev_next;
        head_reg  <= head_next;
        res_reg   <= res_next;
        if ((state_reg == S_DONE) && out_free)
            choice_reg <= res_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buffer_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= buffer_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign choice    = choice_reg;

endmodule

/* hw/rtl/nrhci_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrhci_hash
// Multi-cycle 32-bit avalanche hash; one shared multiplier, one product a cycle.
// ----------------------------------------------------------------------------
module nrhci_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] operand,
    output logic        done,
    output logic [31:0] hash
);

    logic [31:0] acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] seeded;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] product;

    assign seeded = operand + nrhci_pkg::HASH_SEED;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                mul_a = acc_reg;
                mul_b = nrhci_pkg::HASH_MUL_A;
            end
            2'd1:
            begin
                mul_a = acc_reg ^ (acc_reg >> 15);
                mul_b = nrhci_pkg::HASH_MUL_B;
            end
            default:
            begin
                mul_a = acc_reg ^ (acc_reg >> 13);
                mul_b = nrhci_pkg::HASH_MUL_C;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            acc_reg <= {seeded[14:0], seeded[31:15]};
        else if (busy_reg)
            acc_reg <= product;
    end

    assign done = done_reg;
    assign hash = acc_reg ^ (acc_reg >> 16);

endmodule

/* hw/rtl/nrhci_fmod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrhci_fmod
// Iterative floored remainder of a signed 32-bit word by a 16-bit divisor.
// ----------------------------------------------------------------------------
module nrhci_fmod (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] value,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] result
);

    localparam int unsigned CNT_W = $clog2(nrhci_pkg::FMOD_STEPS);

    logic [31:0]      mag_reg;
    logic [15:0]      rem_reg;
    logic [15:0]      div_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      mag_step;
    logic [15:0]      rem_step;

    always_comb
    begin
        logic [16:0] trial;
        rem_step = rem_reg;
        mag_step = mag_reg;
        for (int k = 0; k < nrhci_pkg::FMOD_BITS; k++)
        begin
            trial    = {rem_step, mag_step[31]};
            mag_step = {mag_step[30:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                trial = trial - {1'b0, div_reg};
            rem_step = trial[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(nrhci_pkg::FMOD_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= value[31];
            mag_reg <= value[31] ? (~value + 32'd1) : value;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_step;
            rem_reg <= rem_step;
        end
    end

    assign done   = done_reg;
    assign result = (neg_reg && (rem_reg != 16'd0)) ? (div_reg - rem_reg) : rem_reg;

endmodule

/* hw/rtl/nrhci_hmod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrhci_hmod
// Hash-then-reduce unit: chains the avalanche hash into the remainder unit,
// or reduces the operand directly when hashing is off.
// ----------------------------------------------------------------------------
module nrhci_hmod (
    input  logic               clk,
    input  logic               rst_n,
    input  nrhci_pkg::hm_req_t req,
    output nrhci_pkg::hm_resp_t resp
);

    logic [15:0] div_reg;
    logic        hash_done;
    logic [31:0] hash_value;
    logic        mod_start;
    logic [31:0] mod_value;
    logic [15:0] mod_div;

    nrhci_hash u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (req.start && req.hash_en),
        .operand (req.operand),
        .done    (hash_done),
        .hash    (hash_value)
    );

    always_ff @(posedge clk)
    begin
        if (req.start)
            div_reg <= req.divisor;
    end

    assign mod_start = (req.start && !req.hash_en) || hash_done;
    assign mod_value = hash_done ? hash_value : req.operand;
    assign mod_div   = req.start ? req.divisor : div_reg;

    nrhci_fmod u_fmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .value   (mod_value),
        .divisor (mod_div),
        .done    (resp.done),
        .result  (resp.result)
    );

endmodule
